>>> src/garp_pkg.sv
// Shared types and constants for the gate array register, status and RAM decode logic.
package garp_pkg;

	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned PORT_W  = 16;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned KB_W    = 10;
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned SYSCTL_W = 6;
	localparam int unsigned RAMCTL_W = 7;

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_IO_READ   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_IO_WRITE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MEM_DECODE = 2'd2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_INSTALLED_KB  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_DISK_PRESENT  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FPU_PRESENT   = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_MASK_PORT     = 2'd3;

	// I/O ports
	localparam logic [PORT_W-1:0] PORT_SYSCTL  = 16'h0061;
	localparam logic [PORT_W-1:0] PORT_STATUS  = 16'h0062;
	localparam logic [PORT_W-1:0] PORT_SELECT  = 16'h0065;
	localparam logic [PORT_W-1:0] PORT_RAMCTL  = 16'h006b;
	localparam logic [PORT_W-1:0] PORT_IRQMASK = 16'h00a1;

	localparam logic [DATA_W-1:0] SYSCTL_MASK  = 8'h33;
	localparam logic [DATA_W-1:0] SELECT_MASK  = 8'h9f;
	localparam logic [DATA_W-1:0] RAMCTL_MASK  = 8'h7f;
	localparam logic [DATA_W-1:0] A1_READ_ONES = 8'hfe;
	localparam logic [DATA_W-1:0] OPEN_BUS     = 8'hff;

	localparam logic [ADDR_W-1:0] SEG_TOP     = 20'ha0000;
	localparam logic [ADDR_W-1:0] REMAP_START = 20'h40000;
	localparam logic [ADDR_W-1:0] BANK_TOP    = 20'h80000;
	localparam logic [ADDR_W-1:0] LOW_BANK    = 20'h20000;

	localparam logic [KB_W-1:0] KB_512     = 10'd512;
	localparam logic [KB_W-1:0] KB_640     = 10'd640;
	localparam logic [KB_W-1:0] KB_RESET   = 10'd640;

	typedef struct packed {
		logic [KB_W-1:0] installed_kb;
		logic            disk_present;
		logic            fpu_present;
		logic            mask_port_present;
	} cfg_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PORT_W-1:0] io_port;
		logic [ADDR_W-1:0] mem_address;
		logic [DATA_W-1:0] write_data;
		logic              speaker_level;
	} item_t;

	typedef struct packed {
		logic [SYSCTL_W-1:0] system_control;
		logic [DATA_W-1:0]   select_control;
		logic [RAMCTL_W-1:0] ram_config;
		logic                clock_irq_mask;
	} regs_t;

endpackage

>>> src/garp_if.sv
// Handshake channels: bus item in, result out, configuration writes.
interface garp_req_if;
	logic                               valid;
	logic                               ready;
	logic [garp_pkg::FUNC_W-1:0]        func;
	logic [garp_pkg::PORT_W-1:0]        io_port;
	logic [garp_pkg::ADDR_W-1:0]        mem_address;
	logic [garp_pkg::DATA_W-1:0]        write_data;
	logic                               speaker_level;

	modport source (output valid, func, io_port, mem_address, write_data, speaker_level,
		input ready);
	modport sink (input valid, func, io_port, mem_address, write_data, speaker_level,
		output ready);
endinterface

interface garp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [garp_pkg::DATA_W-1:0]        read_data;
	logic                               ram_hit;
	logic [garp_pkg::ADDR_W-1:0]        ram_offset;
	logic [garp_pkg::DATA_W-1:0]        chip_selects;
	logic [garp_pkg::SYSCTL_W-1:0]      speaker_bits;
	logic                               irq_mask;

	modport source (output valid, read_data, ram_hit, ram_offset, chip_selects,
		speaker_bits, irq_mask, input ready);
	modport sink (input valid, read_data, ram_hit, ram_offset, chip_selects,
		speaker_bits, irq_mask, output ready);
endinterface

interface garp_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [garp_pkg::CIDX_W-1:0]        index;
	logic [garp_pkg::KB_W-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/gate_array_ram_remap_and_ports.sv
// Path: an item goes through an input stage and a result register, which decouple the sides.
// Throughput: one item per cycle while the result side is not stalled.
// The work per item is one register-file update plus one decode compare.
// Reset (arst_n low): pipeline empties, system/RAM control and IRQ mask clear,
// chip selects return to 9Fh, configuration returns to 640 KB, disk present, no FPU,
// no mask port.
module gate_array_ram_remap_and_ports (
	input  logic        clk,
	input  logic        arst_n,
	garp_req_if.sink    req,
	garp_rsp_if.source  rsp,
	garp_cfg_if.sink    cfg
);

	garp_pkg::cfg_t  cfg_q;
	garp_pkg::item_t item_s1;
	logic            valid_s1;
	logic            out_valid_q;
	logic            advance;

	logic [garp_pkg::DATA_W-1:0] read_data;
	garp_pkg::regs_t             regs_nxt;
	logic                        dec_hit;
	logic [garp_pkg::ADDR_W-1:0] dec_offset;
	logic                        is_decode;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.installed_kb      <= garp_pkg::KB_RESET;
			cfg_q.disk_present      <= 1'b1;
			cfg_q.fpu_present       <= 1'b0;
			cfg_q.mask_port_present <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				garp_pkg::CFG_INSTALLED_KB: cfg_q.installed_kb      <= cfg.data;
				garp_pkg::CFG_DISK_PRESENT: cfg_q.disk_present      <= cfg.data[0];
				garp_pkg::CFG_FPU_PRESENT:  cfg_q.fpu_present       <= cfg.data[0];
				garp_pkg::CFG_MASK_PORT:    cfg_q.mask_port_present <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func          <= req.func;
			item_s1.io_port       <= req.io_port;
			item_s1.mem_address   <= req.mem_address;
			item_s1.write_data    <= req.write_data;
			item_s1.speaker_level <= req.speaker_level;
		end
	end

	garp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.read_data (read_data),
		.regs_nxt  (regs_nxt)
	);

	garp_decode u_decode (
		.mem_address  (item_s1.mem_address),
		.ram_config   (regs_nxt.ram_config),
		.installed_kb (cfg_q.installed_kb),
		.hit          (dec_hit),
		.offset       (dec_offset)
	);

	assign is_decode = (item_s1.func == garp_pkg::FUNC_MEM_DECODE);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.read_data    <= read_data;
			rsp.ram_hit      <= is_decode && dec_hit;
			rsp.ram_offset   <= is_decode ? dec_offset : '0;
			rsp.chip_selects <= regs_nxt.select_control;
			rsp.speaker_bits <= regs_nxt.system_control;
			rsp.irq_mask     <= regs_nxt.clock_irq_mask;
		end
	end

	// A stalled input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped an item");

	a_miss_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ram_hit |-> rsp.ram_offset == '0)
		else $error("nonzero offset on a miss");

	// A RAM hit comes only from a decode, which returns no read byte
	a_hit_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rsp.ram_hit |-> rsp.read_data == '0)
		else $error("read data on a decode hit");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rsp.ram_hit |-> rsp.ram_offset < {cfg_q.installed_kb, 10'd0})
		else $error("hit offset beyond installed memory");

endmodule

>>> src/garp_regs.sv
// Register file: port writes, read mux with status byte, next-state export.
module garp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  garp_pkg::item_t               item,
	input  garp_pkg::cfg_t                cfg,
	output logic [garp_pkg::DATA_W-1:0]   read_data,
	output garp_pkg::regs_t               regs_nxt
);

	garp_pkg::regs_t regs_q;
	logic            is_write;
	logic            is_read;
	logic [garp_pkg::DATA_W-1:0] rd_mux;

	assign is_write = (item.func == garp_pkg::FUNC_IO_WRITE);
	assign is_read  = (item.func == garp_pkg::FUNC_IO_READ);

	always_comb begin
		regs_nxt = regs_q;
		if (is_write) begin
			case (item.io_port)
				garp_pkg::PORT_SYSCTL: begin
					regs_nxt.system_control =
						garp_pkg::SYSCTL_W'(item.write_data & garp_pkg::SYSCTL_MASK);
				end
				garp_pkg::PORT_SELECT: begin
					regs_nxt.select_control = item.write_data & garp_pkg::SELECT_MASK;
				end
				garp_pkg::PORT_RAMCTL: begin
					regs_nxt.ram_config =
						garp_pkg::RAMCTL_W'(item.write_data & garp_pkg::RAMCTL_MASK);
				end
				garp_pkg::PORT_IRQMASK: begin
					if (cfg.mask_port_present) begin
						regs_nxt.clock_irq_mask = item.write_data[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (item.io_port)
			garp_pkg::PORT_SYSCTL: rd_mux = garp_pkg::DATA_W'(regs_q.system_control);
			garp_pkg::PORT_STATUS: begin
				rd_mux = {2'b00, item.speaker_level, 2'b00, ~cfg.disk_present,
					cfg.fpu_present, 1'b1};
			end
			garp_pkg::PORT_SELECT: rd_mux = regs_q.select_control;
			garp_pkg::PORT_RAMCTL: rd_mux = garp_pkg::DATA_W'(regs_q.ram_config);
			garp_pkg::PORT_IRQMASK: begin
				if (cfg.mask_port_present) begin
					rd_mux = garp_pkg::A1_READ_ONES |
						garp_pkg::DATA_W'(regs_q.clock_irq_mask);
				end else begin
					rd_mux = garp_pkg::OPEN_BUS;
				end
			end
			default: rd_mux = garp_pkg::OPEN_BUS;
		endcase
	end

	assign read_data = is_read ? rd_mux : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.system_control <= '0;
			regs_q.select_control <= garp_pkg::SELECT_MASK;
			regs_q.ram_config     <= '0;
			regs_q.clock_irq_mask <= 1'b0;
		end else if (advance) begin
			regs_q <= regs_nxt;
		end
	end

	// Registers move only on a processed item
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(regs_q))
		else $error("register file changed without an item");

	// Masked-off select bits never get set
	a_select_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(regs_q.select_control & ~garp_pkg::SELECT_MASK) == '0)
		else $error("select control holds bits outside its mask");

endmodule

>>> src/garp_decode.sv
// Low-RAM address decoder: segment disables, bank remap and size limit.
module garp_decode (
	input  logic [garp_pkg::ADDR_W-1:0]   mem_address,
	input  logic [garp_pkg::RAMCTL_W-1:0] ram_config,
	input  logic [garp_pkg::KB_W-1:0]     installed_kb,
	output logic                          hit,
	output logic [garp_pkg::ADDR_W-1:0]   offset
);

	logic [3:0]                    seg;
	logic [2:0]                    seg_bit;
	logic [garp_pkg::RAMCTL_W:0]   cfg_ext;
	logic                          seg_off;
	logic                          bank_miss;
	logic [garp_pkg::ADDR_W-1:0]   off;
	logic [garp_pkg::ADDR_W-1:0]   limit;

	assign seg     = mem_address[garp_pkg::ADDR_W-1 -: 4];
	assign seg_bit = 3'(seg - 4'd3);
	assign cfg_ext = {1'b0, ram_config};
	assign seg_off = (mem_address >= garp_pkg::REMAP_START) && cfg_ext[seg_bit];
	assign limit   = {installed_kb, 10'd0};

	always_comb begin
		bank_miss = 1'b0;
		if (ram_config[0]) begin
			bank_miss = (mem_address >= garp_pkg::BANK_TOP);
			off = mem_address +
				((installed_kb == garp_pkg::KB_640) ? garp_pkg::LOW_BANK : '0);
		end else if (installed_kb == garp_pkg::KB_512) begin
			bank_miss = (mem_address < garp_pkg::LOW_BANK);
			off = mem_address - garp_pkg::LOW_BANK;
		end else begin
			off = mem_address;
		end
	end

	assign hit    = (mem_address < garp_pkg::SEG_TOP) && !seg_off && !bank_miss &&
		(off < limit);
	assign offset = hit ? off : '0;

endmodule

>>> dv/garp_bus_check.sv
// Result checker for the gate array: shadows the registers, predicts each result and compares.
module garp_bus_check
	import garp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	garp_req_if  req,
	garp_rsp_if  rsp,
	garp_cfg_if  cfg,
	output int   fails,
	output int   pending,
	output int   checked,
	output int   decode_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [DATA_W-1:0] STS_BASE    = 8'h01;
	localparam logic [DATA_W-1:0] STS_FPU     = 8'h02;
	localparam logic [DATA_W-1:0] STS_NO_DISK = 8'h04;
	localparam logic [DATA_W-1:0] STS_SPEAKER = 8'h20;

	typedef struct packed {
		logic [DATA_W-1:0]   read_data;
		logic                ram_hit;
		logic [ADDR_W-1:0]   ram_offset;
		logic [DATA_W-1:0]   chip_selects;
		logic [SYSCTL_W-1:0] speaker_bits;
		logic                irq_mask;
	} bus_result_t;

	cfg_t        shadow_cfg;
	regs_t       shadow_regs;
	bus_result_t result_q[$];

	// Apply one bus transfer to the shadow registers and return the result it should give.
	function automatic bus_result_t predict_access(input item_t it);
		bus_result_t r;
		logic [DATA_W-1:0] masked;
		int unsigned addr, off, seg, kb_bytes;
		logic hit;
		r = '0;
		case (it.func)
		FUNC_IO_READ: begin
			case (it.io_port)
			PORT_SYSCTL: r.read_data = {2'b00, shadow_regs.system_control};
			PORT_STATUS: begin
				r.read_data = STS_BASE;
				if (it.speaker_level) r.read_data |= STS_SPEAKER;
				if (!shadow_cfg.disk_present) r.read_data |= STS_NO_DISK;
				if (shadow_cfg.fpu_present) r.read_data |= STS_FPU;
			end
			PORT_SELECT: r.read_data = shadow_regs.select_control;
			PORT_RAMCTL: r.read_data = {1'b0, shadow_regs.ram_config};
			PORT_IRQMASK: begin
				if (shadow_cfg.mask_port_present)
					r.read_data = A1_READ_ONES | {7'b0, shadow_regs.clock_irq_mask};
				else
					r.read_data = OPEN_BUS;
			end
			default: r.read_data = OPEN_BUS;
			endcase
		end
		FUNC_IO_WRITE: begin
			case (it.io_port)
			PORT_SYSCTL: begin
				masked = it.write_data & SYSCTL_MASK;
				shadow_regs.system_control = masked[SYSCTL_W-1:0];
			end
			PORT_SELECT: shadow_regs.select_control = it.write_data & SELECT_MASK;
			PORT_RAMCTL: begin
				masked = it.write_data & RAMCTL_MASK;
				shadow_regs.ram_config = masked[RAMCTL_W-1:0];
			end
			PORT_IRQMASK: begin
				if (shadow_cfg.mask_port_present)
					shadow_regs.clock_irq_mask = it.write_data[0];
			end
			default: ;
			endcase
		end
		FUNC_MEM_DECODE: begin
			addr = 32'(it.mem_address);
			off = addr;
			hit = 1'b1;
			if (addr >= SEG_TOP) begin
				hit = 1'b0;
			end else if (addr >= REMAP_START) begin
				// 64K segments 4..9 map onto RAM-control bits 1..6
				seg = 32'(it.mem_address[ADDR_W-1:16]) - 32'd3;
				if (shadow_regs.ram_config[seg]) hit = 1'b0;
			end
			if (hit) begin
				if (shadow_regs.ram_config[0]) begin
					if (addr >= BANK_TOP) hit = 1'b0;
					else if (shadow_cfg.installed_kb == KB_640) off = addr + LOW_BANK;
				end else if (shadow_cfg.installed_kb == KB_512) begin
					if (addr < LOW_BANK) hit = 1'b0;
					else off = addr - LOW_BANK;
				end
			end
			kb_bytes = 32'(shadow_cfg.installed_kb);
			kb_bytes = kb_bytes << 10;
			if (hit && off >= kb_bytes) hit = 1'b0;
			r.ram_hit = hit;
			if (hit) r.ram_offset = off[ADDR_W-1:0];
		end
		default: ;
		endcase
		r.chip_selects = shadow_regs.select_control;
		r.speaker_bits = shadow_regs.system_control;
		r.irq_mask = shadow_regs.clock_irq_mask;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_result_t got, want;
		item_t it;
		if (!arst_n) begin
			shadow_cfg = '{installed_kb: KB_RESET, disk_present: 1'b1,
				fpu_present: 1'b0, mask_port_present: 1'b0};
			shadow_regs = '{system_control: '0, select_control: SELECT_MASK,
				ram_config: '0, clock_irq_mask: 1'b0};
			result_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
			decode_hits = 0;
		end else begin
			// results leave only after their transfer has passed the input stage and result register, so check before predicting
			if (rsp.valid && rsp.ready) begin
				got = {rsp.read_data, rsp.ram_hit, rsp.ram_offset, rsp.chip_selects,
					rsp.speaker_bits, rsp.irq_mask};
				checked++;
				if (result_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, expected none, got %h", $time, got);
				end else begin
					want = result_q.pop_front();
					if (got.read_data !== want.read_data) begin
						fails++;
						$display("%0t: read_data expected %02h, got %02h", $time,
							want.read_data, got.read_data);
					end
					if (got.ram_hit !== want.ram_hit) begin
						fails++;
						$display("%0t: ram_hit expected %b, got %b", $time,
							want.ram_hit, got.ram_hit);
					end
					if (got.ram_offset !== want.ram_offset) begin
						fails++;
						$display("%0t: ram_offset expected %05h, got %05h", $time,
							want.ram_offset, got.ram_offset);
					end
					if (got.chip_selects !== want.chip_selects) begin
						fails++;
						$display("%0t: chip_selects expected %02h, got %02h", $time,
							want.chip_selects, got.chip_selects);
					end
					if (got.speaker_bits !== want.speaker_bits) begin
						fails++;
						$display("%0t: speaker_bits expected %02h, got %02h", $time,
							want.speaker_bits, got.speaker_bits);
					end
					if (got.irq_mask !== want.irq_mask) begin
						fails++;
						$display("%0t: irq_mask expected %b, got %b", $time,
							want.irq_mask, got.irq_mask);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_INSTALLED_KB: shadow_cfg.installed_kb = cfg.data;
				CFG_DISK_PRESENT: shadow_cfg.disk_present = cfg.data[0];
				CFG_FPU_PRESENT: shadow_cfg.fpu_present = cfg.data[0];
				CFG_MASK_PORT: shadow_cfg.mask_port_present = cfg.data[0];
				default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				it = '{func: req.func, io_port: req.io_port, mem_address: req.mem_address,
					write_data: req.write_data, speaker_level: req.speaker_level};
				want = predict_access(it);
				if (want.ram_hit) decode_hits++;
				result_q.push_back(want);
			end
			pending = result_q.size();
		end
	end

endmodule

>>> dv/tb_gate_array_ram_remap_and_ports.sv
// Testbench top: clock, reset, bus and configuration stimulus, and the final verdict.
module tb_gate_array_ram_remap_and_ports;
	timeunit 1ns;
	timeprecision 1ps;
	import garp_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 240;

	logic clk;
	logic arst_n;
	int   fail_count, pending_results, checked_count, hit_count;
	int   send_idle_pct, rsp_stall_pct;
	int   settings_used;
	logic [KB_W-1:0] cur_kb;

	garp_req_if req_ch();
	garp_rsp_if rsp_ch();
	garp_cfg_if cfg_ch();

	gate_array_ram_remap_and_ports dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	garp_bus_check bus_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.fails       (fail_count),
		.pending     (pending_results),
		.checked     (checked_count),
		.decode_hits (hit_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[gate_array_ram_remap_and_ports] ERROR");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	function automatic item_t mk_item(input logic [FUNC_W-1:0] f, input logic [PORT_W-1:0] port,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wd, input logic spk);
		item_t it;
		it = '{func: f, io_port: port, mem_address: addr, write_data: wd, speaker_level: spk};
		return it;
	endfunction

	function automatic item_t random_access();
		item_t it;
		int unsigned pick;
		int unsigned kb_edge;
		pick = $urandom_range(99);
		if (pick < 30) it.func = FUNC_IO_READ;
		else if (pick < 62) it.func = FUNC_IO_WRITE;
		else if (pick < 97) it.func = FUNC_MEM_DECODE;
		else it.func = FUNC_UNUSED;
		case ($urandom_range(9))
		0: it.io_port = PORT_SYSCTL;
		1: it.io_port = PORT_STATUS;
		2: it.io_port = PORT_SELECT;
		3, 4: it.io_port = PORT_RAMCTL;
		5, 6: it.io_port = PORT_IRQMASK;
		7: it.io_port = PORT_SYSCTL + PORT_W'($urandom_range(0, 15)) - PORT_W'(1);
		default: it.io_port = PORT_W'($urandom());
		endcase
		kb_edge = 32'(cur_kb);
		kb_edge = kb_edge << 10;
		case ($urandom_range(9))
		0: it.mem_address = ADDR_W'(kb_edge) - ADDR_W'($urandom_range(0, 1));
		1: it.mem_address = ADDR_W'(kb_edge) - LOW_BANK - ADDR_W'($urandom_range(0, 1));
		2: it.mem_address = LOW_BANK - ADDR_W'($urandom_range(0, 1));
		3: it.mem_address = ADDR_W'($urandom_range(0, 6) << 16) + REMAP_START
			- ADDR_W'($urandom_range(0, 1));
		4, 5: it.mem_address = ADDR_W'($urandom());
		default: it.mem_address = ADDR_W'($urandom_range(0, SEG_TOP - 1));
		endcase
		it.write_data = DATA_W'($urandom());
		// keep RAM control mostly sparse so decodes reach the high segments
		if (it.io_port == PORT_RAMCTL && $urandom_range(1)) it.write_data &= 8'h81;
		it.speaker_level = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic send_access(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= it.func;
		req_ch.io_port <= it.io_port;
		req_ch.mem_address <= it.mem_address;
		req_ch.write_data <= it.write_data;
		req_ch.speaker_level <= it.speaker_level;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [KB_W-1:0] kb, input logic disk, input logic fpu,
			input logic mask_port);
		logic [KB_W-1:0] values [4];
		values = '{kb, {9'b0, disk}, {9'b0, fpu}, {9'b0, mask_port}};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= CIDX_W'(i);
			cfg_ch.data <= values[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		cur_kb = kb;
		settings_used++;
	endtask

	initial begin
		logic [KB_W-1:0] kb;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_IO_READ;
		req_ch.io_port = '0;
		req_ch.mem_address = '0;
		req_ch.write_data = '0;
		req_ch.speaker_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_INSTALLED_KB;
		cfg_ch.data = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		settings_used = 1;
		cur_kb = KB_RESET;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, status bits, absent mask port, open bus, write masks and decode edges
		send_access(mk_item(FUNC_IO_READ, PORT_SYSCTL, '0, '0, 1'b0));
		send_access(mk_item(FUNC_IO_READ, PORT_STATUS, '0, '0, 1'b0));
		send_access(mk_item(FUNC_IO_READ, PORT_STATUS, '1, '1, 1'b1));
		send_access(mk_item(FUNC_IO_READ, PORT_SELECT, '0, '0, 1'b0));
		send_access(mk_item(FUNC_IO_READ, PORT_RAMCTL, '0, '0, 1'b0));
		send_access(mk_item(FUNC_IO_WRITE, PORT_IRQMASK, '0, 8'hff, 1'b0));
		send_access(mk_item(FUNC_IO_READ, PORT_IRQMASK, '0, '0, 1'b0));
		send_access(mk_item(FUNC_IO_READ, 16'h0000, '0, '0, 1'b0));
		send_access(mk_item(FUNC_IO_READ, 16'hffff, '1, '1, 1'b1));
		send_access(mk_item(FUNC_IO_WRITE, PORT_SYSCTL, '0, 8'hff, 1'b0));
		send_access(mk_item(FUNC_IO_WRITE, PORT_SELECT, '0, 8'h00, 1'b0));
		send_access(mk_item(FUNC_IO_WRITE, PORT_STATUS, '0, 8'hff, 1'b0));
		send_access(mk_item(FUNC_UNUSED, '1, '1, '1, 1'b1));
		send_access(mk_item(FUNC_IO_WRITE, PORT_RAMCTL, '0, 8'hff, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, 20'h00000, '0, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, 20'h3ffff, '0, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, REMAP_START, '0, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '1, 20'hfffff, '0, 1'b0));
		send_access(mk_item(FUNC_IO_WRITE, PORT_RAMCTL, '0, 8'h00, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, SEG_TOP - 20'd1, '0, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, SEG_TOP, '0, 1'b0));
		send_access(mk_item(FUNC_IO_WRITE, PORT_SELECT, '0, 8'hff, 1'b0));
		send_access(mk_item(FUNC_IO_WRITE, PORT_RAMCTL, '0, 8'h01, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, BANK_TOP - 20'd1, '0, 1'b0));
		send_access(mk_item(FUNC_MEM_DECODE, '0, BANK_TOP, '0, 1'b0));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			case (p)
			0: kb = KB_640;
			1: kb = KB_512;
			2: kb = '0;
			3: kb = 10'd256;
			4: kb = KB_W'($urandom_range(1, 639));
			default: kb = KB_640;
			endcase
			apply_setting(kb, (p % 3) != 1, p[0], (p != 0 && p != 3));
			// idle mix: none, sender, receiver, both
			case (p % 4)
			0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
			1: begin send_idle_pct = 82; rsp_stall_pct = 0; end
			2: begin send_idle_pct = 0; rsp_stall_pct = 82; end
			default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
			endcase
			repeat (ITEMS_PER_PHASE) send_access(random_access());
		end
		drain_results();
		repeat (4) @(posedge clk);

		$display("Summary: %0d results checked under %0d memory/port settings, %0d RAM hits,",
			checked_count, settings_used, hit_count);
		$display("  with idle-free, sender-idle, receiver-stall and mixed handshake phases");
		if (fail_count == 0 && pending_results == 0) begin
			$display("[gate_array_ram_remap_and_ports] OK");
		end else begin
			$display("[gate_array_ram_remap_and_ports] ERROR");
		end
		$finish;
	end

endmodule
